// ===== sv/keyed_table_merge_gate_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef KEYED_TABLE_MERGE_GATE_CORE_MACROS_SVH
`define KEYED_TABLE_MERGE_GATE_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define KTMG_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define KTMG_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/ktmg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ktmg_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SCAN_MAX    = 32;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SCAN_W = $clog2(SCAN_MAX + 1);

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_MERGE  = 3'd1;
    localparam logic [2:0] CMD_UPSERT = 3'd2;
    localparam logic [2:0] CMD_LOOKUP = 3'd3;
    localparam logic [2:0] CMD_SCAN   = 3'd4;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_MERGE,
        OP_UPSERT,
        OP_LOOKUP,
        OP_SCAN,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] geo;
        logic [16:0] score;
        logic [16:0] fail;
        logic [31:0] cnt;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        op_t  op;
        rec_t rec;
        logic eod;
    } item_t;

    typedef struct packed {
        rec_t       rec;
        logic       found;
        logic       accepted;
        logic       stored;
        logic [7:0] acnt;
        logic       valid_res;
        logic       last;
    } res_t;

endpackage
`default_nettype wire

// ===== sv/keyed_table_merge_gate_core.sv =====
// Keyed record table with a score-gated merge. Items enter a two-entry
// queue and are carried out one at a time by a sequencer that walks the
// table memory linearly, handling each stored entry in turn (address,
// then compare on the registered read data); a merge, upsert or lookup
// stops at the first matching key, and a scan walks all stored entries
// or stops after SCAN_MAX matches. Clear and unused commands, and any
// command on an empty table, skip the walk. Each item then waits for its
// result to be taken before the next item is started, and a scan also
// waits for each of its earlier results to be taken.
// The table memory needs no clearing after reset, since only entries
// below the fill count are ever read. The threshold register may be
// written only while the block is idle. Results leave through a single
// output register, so the two-entry queue keeps accepting items while a
// result waits to be taken, until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module keyed_table_merge_gate_core import ktmg_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [16:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [31:0] s_rec_key,
    input  wire logic [31:0] s_geometry_ref,
    input  wire logic [16:0] s_mean_f1,
    input  wire logic [16:0] s_fail_rate,
    input  wire logic [31:0] s_samples,
    input  wire logic        s_end_of_delta,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_out_rec_key,
    output logic [31:0]      m_out_geometry_ref,
    output logic [16:0]      m_out_mean_f1,
    output logic [16:0]      m_out_fail_rate,
    output logic [31:0]      m_out_samples,
    output logic             m_found,
    output logic             m_accepted,
    output logic             m_stored,
    output logic [7:0]       m_accepted_count,
    output logic             m_valid_res,
    output logic             m_last
);

    logic  q_valid;
    item_t q_item;
    logic  q_pop;
    logic  res_valid;
    res_t  res;
    logic  res_ready;
    logic  m_valid_reg;
    res_t  out_reg;

    // The front end decodes commands and buffers them.
    ktmg_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_rec_key      (s_rec_key),
        .s_geometry_ref (s_geometry_ref),
        .s_mean_f1      (s_mean_f1),
        .s_fail_rate    (s_fail_rate),
        .s_samples      (s_samples),
        .s_end_of_delta (s_end_of_delta),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    // The back end owns the table, the counters and the threshold.
    ktmg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

    // The output register takes a new result whenever it is empty or its
    // current result is being taken in the same cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_rec_key      = out_reg.rec.key;
    assign m_out_geometry_ref = out_reg.rec.geo;
    assign m_out_mean_f1      = out_reg.rec.score;
    assign m_out_fail_rate    = out_reg.rec.fail;
    assign m_out_samples      = out_reg.rec.cnt;
    assign m_found            = out_reg.found;
    assign m_accepted         = out_reg.accepted;
    assign m_stored           = out_reg.stored;
    assign m_accepted_count   = out_reg.acnt;
    assign m_valid_res        = out_reg.valid_res;
    assign m_last             = out_reg.last;

endmodule
`default_nettype wire

// ===== sv/ktmg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ktmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         aclk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/ktmg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ktmg_front import ktmg_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [31:0] s_rec_key,
    input  wire logic [31:0] s_geometry_ref,
    input  wire logic [16:0] s_mean_f1,
    input  wire logic [16:0] s_fail_rate,
    input  wire logic [31:0] s_samples,
    input  wire logic        s_end_of_delta,
    output logic             q_valid,
    output item_t            q_item,
    input  wire logic        q_pop
);

    // Two-entry queue of decoded items.
    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    item_t      in_item;
    logic       push;
    logic       pop;

    always_comb begin
        unique case (s_cmd)
            CMD_CLEAR:  in_item.op = OP_CLEAR;
            CMD_MERGE:  in_item.op = OP_MERGE;
            CMD_UPSERT: in_item.op = OP_UPSERT;
            CMD_LOOKUP: in_item.op = OP_LOOKUP;
            CMD_SCAN:   in_item.op = OP_SCAN;
            default:    in_item.op = OP_NOP;
        endcase
        in_item.rec.key   = s_rec_key;
        in_item.rec.geo   = s_geometry_ref;
        in_item.rec.score = s_mean_f1;
        in_item.rec.fail  = s_fail_rate;
        in_item.rec.cnt   = s_samples;
        in_item.eod       = s_end_of_delta;
    end

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ktmg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ktmg_back import ktmg_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [16:0] cfg_wr_data,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    output logic             res_valid,
    output res_t             res,
    input  wire logic        res_ready
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    item_t             cur_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    rec_t              hit_reg, hit_next;
    logic              held_valid_reg, held_valid_next;
    rec_t              held_reg, held_next;
    logic [SCAN_W-1:0] nmatch_reg, nmatch_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [7:0]        delta_reg, delta_next;
    logic [16:0]       thr_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    rec_t              ram_rdata;
    logic [REC_W-1:0]  ram_rdata_raw;

    logic              last_entry;
    logic              full;
    logic [16:0]       prior_score;
    logic [17:0]       gate_sum;
    logic              gate_pass;
    logic [7:0]        delta_inc;
    logic              scan_match;
    logic              can_store;

    ktmg_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cur_reg.rec),
        .raddr (idx_reg),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata   = rec_t'(ram_rdata_raw);
    assign last_entry  = (CNT_W'(idx_reg) + CNT_W'(1)) == entry_count_reg;
    assign full        = (entry_count_reg == CNT_W'(TABLE_DEPTH));
    assign prior_score = found_reg ? hit_reg.score : 17'd0;
    assign gate_sum    = {1'b0, prior_score} + {1'b0, thr_reg};
    assign gate_pass   = {1'b0, cur_reg.rec.score} > gate_sum;
    assign delta_inc   = (delta_reg != 8'd255) ? delta_reg + 8'd1 : delta_reg;
    assign scan_match  = ram_rdata.cnt > cur_reg.rec.cnt;
    assign can_store   = found_reg || !full;
    assign ram_waddr   = found_reg ? hit_idx_reg : entry_count_reg[IDX_W-1:0];
    assign q_pop       = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        found_next       = found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_next         = hit_reg;
        held_valid_next  = held_valid_reg;
        held_next        = held_reg;
        nmatch_next      = nmatch_reg;
        entry_count_next = entry_count_reg;
        delta_next       = delta_reg;
        ram_we           = 1'b0;
        res_valid        = 1'b0;
        res              = '0;
        res.acnt         = delta_reg;
        res.last         = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    idx_next        = '0;
                    found_next      = 1'b0;
                    held_valid_next = 1'b0;
                    nmatch_next     = '0;
                    if (q_item.op != OP_CLEAR && q_item.op != OP_NOP &&
                        entry_count_reg != '0) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (cur_reg.op == OP_SCAN) begin
                    // A new match pushes the previously held record out as a
                    // non-final result; wait if the output cannot take it.
                    if (scan_match && held_valid_reg) begin
                        res_valid     = 1'b1;
                        res.rec       = held_reg;
                        res.found     = 1'b1;
                        res.valid_res = 1'b1;
                        res.last      = 1'b0;
                    end
                    if (!(scan_match && held_valid_reg && !res_ready)) begin
                        if (scan_match) begin
                            held_next       = ram_rdata;
                            held_valid_next = 1'b1;
                            nmatch_next     = nmatch_reg + SCAN_W'(1);
                        end
                        if (last_entry ||
                            (scan_match && (nmatch_reg + SCAN_W'(1)) == SCAN_W'(SCAN_MAX)))
                        begin
                            state_next = ST_FIN;
                        end else begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = ST_READ;
                        end
                    end
                end else begin
                    if (ram_rdata.key == cur_reg.rec.key) begin
                        found_next   = 1'b1;
                        hit_next     = ram_rdata;
                        hit_idx_next = idx_reg;
                        state_next   = ST_FIN;
                    end else if (last_entry) begin
                        state_next = ST_FIN;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_FIN: begin
                res_valid = 1'b1;
                unique case (cur_reg.op)
                    OP_CLEAR: begin
                        res.acnt = 8'd0;
                    end
                    OP_MERGE: begin
                        res.rec.key   = cur_reg.rec.key;
                        if (found_reg) begin
                            res.rec.geo   = hit_reg.geo;
                            res.rec.score = hit_reg.score;
                            res.rec.fail  = hit_reg.fail;
                            res.rec.cnt   = hit_reg.cnt;
                        end
                        res.found     = found_reg;
                        res.accepted  = gate_pass;
                        res.stored    = gate_pass && can_store;
                        res.acnt      = gate_pass ? delta_inc : delta_reg;
                        res.valid_res = 1'b1;
                    end
                    OP_UPSERT: begin
                        res.rec       = cur_reg.rec;
                        res.found     = found_reg;
                        res.stored    = can_store;
                        res.valid_res = 1'b1;
                    end
                    OP_LOOKUP: begin
                        if (found_reg) begin
                            res.rec       = hit_reg;
                            res.found     = 1'b1;
                            res.valid_res = 1'b1;
                        end
                    end
                    OP_SCAN: begin
                        if (held_valid_reg) begin
                            res.rec       = held_reg;
                            res.found     = 1'b1;
                            res.valid_res = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                if (res_ready) begin
                    state_next = ST_IDLE;
                    unique case (cur_reg.op)
                        OP_CLEAR: begin
                            entry_count_next = '0;
                            delta_next       = 8'd0;
                        end
                        OP_MERGE: begin
                            if (gate_pass) begin
                                ram_we     = can_store;
                                delta_next = delta_inc;
                                if (!found_reg && !full) begin
                                    entry_count_next = entry_count_reg + CNT_W'(1);
                                end
                            end
                            if (cur_reg.eod) begin
                                delta_next = 8'd0;
                            end
                        end
                        OP_UPSERT: begin
                            ram_we = can_store;
                            if (!found_reg && !full) begin
                                entry_count_next = entry_count_reg + CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            delta_reg       <= 8'd0;
            thr_reg         <= 17'd0;
            held_valid_reg  <= 1'b0;
            found_reg       <= 1'b0;
            nmatch_reg      <= '0;
        end else begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            delta_reg       <= delta_next;
            held_valid_reg  <= held_valid_next;
            found_reg       <= found_next;
            nmatch_reg      <= nmatch_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item;
        end
        idx_reg     <= idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_reg     <= hit_next;
        held_reg    <= held_next;
    end

endmodule
`default_nettype wire

// ===== sv/ktmg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_table_merge_gate_core_macros.svh"
module ktmg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_out_rec_key,
    input wire logic [31:0] m_out_samples,
    input wire logic        m_found,
    input wire logic        m_accepted,
    input wire logic [7:0]  m_accepted_count,
    input wire logic        m_valid_res,
    input wire logic        m_last
);

    // A stalled result holds.
    `KTMG_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_out_rec_key) && $stable(m_last), "stalled result changed")

    // Only a scan gives results that are not last, and each carries a record.
    `KTMG_ASSERT_IMP(a_mid_scan, m_valid && !m_last, m_valid_res && m_found, "non-final result without record")

    // A result without a record has its record fields zero.
    `KTMG_ASSERT_IMP(a_empty_zero, m_valid && !m_valid_res, m_out_rec_key == 32'd0 && m_out_samples == 32'd0 && !m_accepted, "empty result carries data")

    // An accepted merge is always counted.
    `KTMG_ASSERT_IMP(a_acc_count, m_valid && m_accepted, m_accepted_count != 8'd0 && m_valid_res, "accept not counted")

endmodule

bind keyed_table_merge_gate_core ktmg_checker u_ktmg_checker (.*);
`default_nettype wire
